### hdl/scfe_pkg.sv
// Package for the speed command frame encoder.
// Holds the item types, frame marker bytes and sequencer positions.
// No dependencies.
package scfe_pkg;

  localparam int unsigned WORD_BYTES = 12;

  localparam logic [7:0] FRAME_START  = 8'h7E;
  localparam logic [7:0] FRAME_STOP   = 8'h7F;
  localparam logic [7:0] FRAME_ESCAPE = 8'h7D;
  localparam logic [7:0] CMD_SPEED    = 8'h01;

  localparam logic [3:0] POS_START     = 4'd0;
  localparam logic [3:0] POS_ID        = 4'd1;
  localparam logic [3:0] POS_CMD       = 4'd2;
  localparam logic [3:0] POS_DATA_FIRST = 4'd3;
  localparam logic [3:0] POS_DATA_LAST  = 4'd14;
  localparam logic [3:0] POS_STOP      = 4'd15;

  typedef struct packed {
    logic [7:0]  robot_id;
    logic [31:0] speed_x_bits;
    logic [31:0] speed_y_bits;
    logic [31:0] speed_turn_bits;
  } cmd_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } frame_t;

  typedef struct packed {
    logic [7:0]                       robot_id;
    logic [WORD_BYTES-1:0][7:0]       data;
    logic [WORD_BYTES-1:0]            esc;
  } plan_t;

  function automatic logic is_marker(input logic [7:0] b);
    return (b == FRAME_START) || (b == FRAME_ESCAPE) || (b == FRAME_STOP);
  endfunction

endpackage

### hdl/scfe_front.sv
// Front stage: accept a speed command and classify its word bytes.
// Marks each byte that needs an escape; hands the plan to the queue.
// Depends on scfe_pkg.
module scfe_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  scfe_pkg::cmd_t  cmd,
  output logic            plan_valid,
  input  logic            plan_ready,
  output scfe_pkg::plan_t plan
);
  import scfe_pkg::*;

  logic  valid;
  plan_t plan_next;
  logic  take;

  assign full       = valid && !plan_ready;
  assign take       = push && !full;
  assign plan_valid = valid;

  always_comb begin
    plan_next = '0;
    plan_next.robot_id = cmd.robot_id;
    plan_next.data = {cmd.speed_turn_bits, cmd.speed_y_bits, cmd.speed_x_bits};
    for (int i = 0; i < WORD_BYTES; i++) begin
      plan_next.esc[i] = is_marker(plan_next.data[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (plan_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      plan <= plan_next;
    end
  end

endmodule

### hdl/scfe_queue.sv
// Short queue of classified commands between front and back.
// Register array with head and tail pointers and an occupancy count.
// Depends on scfe_pkg.
module scfe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  scfe_pkg::plan_t wr_data,
  output logic            rd_valid,
  input  logic            rd_take,
  output scfe_pkg::plan_t rd_data
);
  import scfe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  plan_t            slots [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;
  assign rd_data  = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_rd) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[tail] <= wr_data;
    end
  end

endmodule

### hdl/scfe_back.sv
// Back stage: walk the frame of the head command, one byte per cycle
// unless stalled. Inserts escapes, drives the registered result.
// Depends on scfe_pkg.
module scfe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             plan_valid,
  output logic             plan_take,
  input  scfe_pkg::plan_t  plan,
  output logic             empty,
  input  logic             pop,
  output scfe_pkg::frame_t frame
);
  import scfe_pkg::*;

  logic [3:0] pos;
  logic       esc_done;
  logic       out_valid;
  logic       advance;
  logic [3:0] data_idx;
  logic [7:0] data_byte;
  frame_t     frame_next;
  logic [3:0] pos_next;
  logic       esc_done_next;

  assign empty     = !out_valid;
  assign advance   = plan_valid && (!out_valid || pop);
  assign data_idx  = pos - POS_DATA_FIRST;
  assign data_byte = plan.data[data_idx];
  assign plan_take = advance && (pos == POS_STOP);

  always_comb begin
    frame_next    = '0;
    pos_next      = pos + 1'b1;
    esc_done_next = 1'b0;
    if (pos inside {[POS_DATA_FIRST:POS_DATA_LAST]}) begin
      if (plan.esc[data_idx] && !esc_done) begin
        frame_next.frame_byte = FRAME_ESCAPE;
        pos_next              = pos;
        esc_done_next         = 1'b1;
      end else begin
        frame_next.frame_byte = data_byte;
      end
    end else begin
      case (pos)
        POS_START: frame_next.frame_byte = FRAME_START;
        POS_ID:    frame_next.frame_byte = plan.robot_id;
        POS_CMD:   frame_next.frame_byte = CMD_SPEED;
        POS_STOP: begin
          frame_next.frame_byte = FRAME_STOP;
          frame_next.frame_end  = 1'b1;
          pos_next              = POS_START;
        end
        default:   frame_next.frame_byte = FRAME_STOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_START;
      esc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      pos       <= pos_next;
      esc_done  <= esc_done_next;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame <= frame_next;
    end
  end

endmodule

### hdl/speed_command_frame_encoder.sv
// Speed command frame encoder: turns each speed command (robot id and three
// 32-bit words) into a byte frame 7E, id, 01, the words low byte first with
// 7D ahead of any 7D/7E/7F byte, then 7F flagged by frame_end. Bytes leave at
// one per cycle from the back sequencer unless stalled; a frame is 16 to 28
// bytes and that sequencer sets the sustained rate. A front register and a
// queue of QUEUE_DEPTH commands let new commands enter while a frame is going
// out. Top level; depends on scfe_pkg, scfe_front, scfe_queue and scfe_back.
module speed_command_frame_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  scfe_pkg::cmd_t   cmd,
  output logic             empty,
  input  logic             pop,
  output scfe_pkg::frame_t frame
);
  import scfe_pkg::*;

  plan_t front_plan;
  plan_t head_plan;
  logic  front_valid;
  logic  queue_ready;
  logic  head_valid;
  logic  head_take;

  scfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .plan_valid (front_valid),
    .plan_ready (queue_ready),
    .plan       (front_plan)
  );

  scfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (queue_ready),
    .wr_data  (front_plan),
    .rd_valid (head_valid),
    .rd_take  (head_take),
    .rd_data  (head_plan)
  );

  scfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .plan_valid (head_valid),
    .plan_take  (head_take),
    .plan       (head_plan),
    .empty      (empty),
    .pop        (pop),
    .frame      (frame)
  );

endmodule

### tb/sv/tb_speed_command_frame_encoder.sv
// Testbench for speed_command_frame_encoder: a directed table and random speed
// commands with bursty push and stalling pop, each byte checked against a frame encoder.
// Depends on scfe_pkg and speed_command_frame_encoder.
`timescale 1ns / 100ps

module tb_speed_command_frame_encoder;
  import scfe_pkg::*;

  localparam int unsigned RANDOM_CMDS = 220;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_START  = 3000;
  localparam int unsigned HOLD_CYCLES = 900;
  localparam int unsigned TAIL_CYCLES = 60;

  typedef struct {
    cmd_t         c;
    int           typed_len;
    logic [223:0] typed;
  } cmd_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   push = 1'b0;
  logic   full;
  cmd_t   cmd = '0;
  logic   empty;
  logic   pop = 1'b0;
  frame_t frame;

  int           row_typed_len = 0;
  logic [223:0] row_typed = '0;

  frame_t      frame_bytes_due[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  cmd_row_t    directed_rows [14];

  speed_command_frame_encoder dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .cmd   (cmd),
    .empty (empty),
    .pop   (pop),
    .frame (frame)
  );

  always #5 clk = ~clk;

  function automatic void queue_frame_byte(input logic [7:0] b, input logic last);
    frame_t f;
    f.frame_byte = b;
    f.frame_end  = last;
    frame_bytes_due.push_back(f);
  endfunction

  function automatic void encode_speed_frame(input cmd_t c);
    logic [31:0] words [3];
    logic [7:0]  b;
    words[0] = c.speed_x_bits;
    words[1] = c.speed_y_bits;
    words[2] = c.speed_turn_bits;
    queue_frame_byte(FRAME_START, 1'b0);
    queue_frame_byte(c.robot_id, 1'b0);
    queue_frame_byte(CMD_SPEED, 1'b0);
    for (int w = 0; w < 3; w++) begin
      for (int i = 0; i < 4; i++) begin
        b = words[w][8*i +: 8];
        if (b == FRAME_START || b == FRAME_ESCAPE || b == FRAME_STOP) begin
          queue_frame_byte(FRAME_ESCAPE, 1'b0);
        end
        queue_frame_byte(b, 1'b0);
      end
    end
    queue_frame_byte(FRAME_STOP, 1'b1);
  endfunction

  function automatic logic [31:0] rand_speed_word();
    logic [31:0] w;
    if ($urandom_range(0, 3) == 0) begin
      w = $urandom;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          w[8*i +: 8] = FRAME_ESCAPE + 8'($urandom_range(0, 2));
        end else begin
          w[8*i +: 8] = 8'($urandom_range(0, 255));
        end
      end
    end
    return w;
  endfunction

  task automatic offer_cmd(input cmd_t c, input int typed_len, input logic [223:0] typed);
    push          <= 1'b1;
    cmd           <= c;
    row_typed_len <= typed_len;
    row_typed     <= typed;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_speed_command_frame_encoder failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (!rst) begin
      if (push && !full) begin
        if (row_typed_len != 0) begin
          for (int i = 0; i < row_typed_len; i++) begin
            queue_frame_byte(row_typed[223 - 8*i -: 8], i == row_typed_len - 1);
          end
        end else begin
          encode_speed_frame(cmd);
        end
      end
      if (pop && !empty) begin
        if (frame_bytes_due.size() == 0) begin
          $error("frame_byte %h arrived with no frame pending", frame.frame_byte);
          mismatches++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (frame.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %h, got %h", want.frame_byte, frame.frame_byte);
            mismatches++;
          end
          if (frame.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, frame.frame_end);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver: rotating stall modes, one long hold-off to back up the block
  initial begin
    int unsigned rx_cycle;
    int unsigned mode;
    logic [7:0]  stall_pattern;
    rx_cycle = 0;
    mode = 0;
    stall_pattern = 8'b1011_0110;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle == HOLD_START) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (rx_cycle % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: begin
            pop <= 1'b1;
          end
          1: begin
            pop <= 1'($urandom_range(0, 1));
          end
          2: begin
            pop <= stall_pattern[rx_cycle[2:0]];
          end
          default: begin
            pop <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    int   burst_left;
    int   gap;
    cmd_t c;

    directed_rows = '{
      '{'{8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 16,
        {FRAME_START, 8'h00, CMD_SPEED, {12{8'h00}}, FRAME_STOP, {96{1'b0}}}},
      '{'{8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 16,
        {FRAME_START, 8'hFF, CMD_SPEED, {12{8'hFF}}, FRAME_STOP, {96{1'b0}}}},
      '{'{8'h00, 32'h7E7E_7E7E, 32'h7E7E_7E7E, 32'h7E7E_7E7E}, 28,
        {FRAME_START, 8'h00, CMD_SPEED, {12{FRAME_ESCAPE, FRAME_START}}, FRAME_STOP}},
      '{'{8'h00, 32'h7D7D_7D7D, 32'h7D7D_7D7D, 32'h7D7D_7D7D}, 28,
        {FRAME_START, 8'h00, CMD_SPEED, {12{FRAME_ESCAPE, FRAME_ESCAPE}}, FRAME_STOP}},
      '{'{8'h00, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 32'h7F7F_7F7F}, 28,
        {FRAME_START, 8'h00, CMD_SPEED, {12{FRAME_ESCAPE, FRAME_STOP}}, FRAME_STOP}},
      '{'{8'h7E, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 16,
        {FRAME_START, FRAME_START, CMD_SPEED, {12{8'h00}}, FRAME_STOP, {96{1'b0}}}},
      '{'{8'h7D, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 16,
        {FRAME_START, FRAME_ESCAPE, CMD_SPEED, {12{8'h00}}, FRAME_STOP, {96{1'b0}}}},
      '{'{8'h7F, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 16,
        {FRAME_START, FRAME_STOP, CMD_SPEED, {12{8'h00}}, FRAME_STOP, {96{1'b0}}}},
      '{'{8'h01, 32'h0000_007E, 32'h007D_0000, 32'h7F00_0000}, 0, '0},
      '{'{8'h7C, 32'h7C80_7B00, 32'h3F80_0000, 32'hBF80_0000}, 0, '0},
      '{'{8'h55, 32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000}, 0, '0},
      '{'{8'hAA, 32'h0000_0001, 32'h807F_FFFF, 32'h8000_0000}, 0, '0},
      '{'{8'h5A, 32'hAAAA_AAAA, 32'h5555_5555, 32'h7E7D_7F01}, 0, '0},
      '{'{8'h80, 32'h017E_7D7F, 32'h7F7E_7D00, 32'h00FF_7E80}, 0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 14; i++) begin
      offer_cmd(directed_rows[i].c, directed_rows[i].typed_len, directed_rows[i].typed);
      if ($urandom_range(0, 2) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end

    burst_left = $urandom_range(1, 12);
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        c.robot_id = FRAME_ESCAPE + 8'($urandom_range(0, 2));
      end else begin
        c.robot_id = 8'($urandom_range(0, 255));
      end
      c.speed_x_bits    = rand_speed_word();
      c.speed_y_bits    = rand_speed_word();
      c.speed_turn_bits = rand_speed_word();
      offer_cmd(c, 0, '0);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 40);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    push <= 1'b0;

    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_speed_command_frame_encoder passed");
    end else begin
      $display("tb_speed_command_frame_encoder failed");
    end
    $finish;
  end

endmodule

### speed_command_frame_encoder.f
hdl/scfe_pkg.sv
hdl/scfe_front.sv
hdl/scfe_queue.sv
hdl/scfe_back.sv
hdl/speed_command_frame_encoder.sv
tb/sv/tb_speed_command_frame_encoder.sv
